@@ hw/rtl/pfc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfc_pkg
// Shared types, codes and helpers for the Playfair encryption block.
// ----------------------------------------------------------------------------
package pfc_pkg;

  localparam int SqDim     = 5;
  localparam int SqCells   = SqDim * SqDim;
  localparam int NumLetter = 26;
  localparam int LetW      = 5;
  localparam int CellW     = 5;

  localparam logic [LetW-1:0] LetI = 5'd8;
  localparam logic [LetW-1:0] LetJ = 5'd9;
  localparam logic [LetW-1:0] LetX = 5'd23;
  localparam logic [LetW-1:0] LetLast = 5'd25;

  typedef logic [LetW-1:0]  letter_t;
  typedef logic [CellW-1:0] cell_t;

  typedef enum logic [1:0] {
    OP_KEY   = 2'd0,
    OP_CLOSE = 2'd1,
    OP_TEXT  = 2'd2,
    OP_END   = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FILL,
    ST_LOOK_A,
    ST_LOOK_B,
    ST_RULE,
    ST_OUT_1,
    ST_READ_2,
    ST_OUT_2
  } state_t;

  typedef struct packed {
    logic    en;
    letter_t letter;
  } place_req_t;

  typedef struct packed {
    logic    ok;
    letter_t idx;
  } letter_dec_t;

  function automatic letter_dec_t letter_of(input logic [7:0] b);
    letter_dec_t d;
    d.ok  = 1'b0;
    d.idx = '0;
    if (b >= 8'h61 && b <= 8'h7a) begin
      d.ok  = 1'b1;
      d.idx = 5'(b - 8'h61);
    end else if (b >= 8'h41 && b <= 8'h5a) begin
      d.ok  = 1'b1;
      d.idx = 5'(b - 8'h41);
    end
    return d;
  endfunction

  function automatic letter_t fold_j(input letter_t l);
    return (l == LetJ) ? LetI : l;
  endfunction

  function automatic logic [2:0] cell_row(input cell_t c);
    logic [2:0] r;
    if (c >= 5'd20)      r = 3'd4;
    else if (c >= 5'd15) r = 3'd3;
    else if (c >= 5'd10) r = 3'd2;
    else if (c >= 5'd5)  r = 3'd1;
    else                 r = 3'd0;
    return r;
  endfunction

  function automatic logic [2:0] cell_col(input cell_t c);
    logic [4:0] base;
    base = 5'(cell_row(c)) * 5'd5;
    return 3'(c - base);
  endfunction

endpackage

@@ hw/rtl/playfair_cipher_encrypt_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// playfair_cipher_encrypt_top
// Playfair encryption of a byte stream: key build, key close and text pairing.
// ----------------------------------------------------------------------------
// Key byte, dropped or non-pairing text byte: ready again next cycle.
// Close key: each letter but J not yet used is placed by the key store port.
// Pair-producing text byte or end: busy until both cipher letters are taken;
// two cell lookups and two square reads go through single memory read ports.
// Reset (synchronous, active low) empties the square and drops any open pair.
// ----------------------------------------------------------------------------
module playfair_cipher_encrypt_top
  import pfc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] char_in
  input  logic [1:0] in_tuser,   // [1:0] operation
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [6:0] cipher_letter, [7] zero fill
  output logic       out_tlast   // pair_end
);

  state_t      state_r, state_nxt;
  logic        closed_r, closed_nxt;
  logic        have_r, have_nxt;
  logic        fja_r, fja_nxt;
  letter_t     pend_r, pend_nxt;
  letter_t     a_r, a_nxt;
  letter_t     b_r, b_nxt;
  letter_t     cnt_r, cnt_nxt;
  cell_t       c1_r, c1_nxt;
  cell_t       o2_r, o2_nxt;

  logic        in_acc;
  op_t         op;
  letter_dec_t dec;
  logic        go_pair;

  place_req_t  place_req;
  logic        cell_rd_en;
  letter_t     cell_rd_addr;
  cell_t       cell_rd_data;
  logic        sq_rd_en;
  cell_t       sq_rd_addr;
  letter_t     sq_rd_data;
  cell_t       rule_o1, rule_o2;

  assign in_acc = in_tvalid && in_tready;
  assign op     = op_t'(in_tuser);
  assign dec    = letter_of(in_tdata);

  pfc_key_store u_store (
    .clk          (clk),
    .rst_n        (rst_n),
    .place_req    (place_req),
    .cell_rd_en   (cell_rd_en),
    .cell_rd_addr (cell_rd_addr),
    .cell_rd_data (cell_rd_data),
    .sq_rd_en     (sq_rd_en),
    .sq_rd_addr   (sq_rd_addr),
    .sq_rd_data   (sq_rd_data)
  );

  pfc_pair_rule u_rule (
    .c1 (c1_r),
    .c2 (cell_rd_data),
    .o1 (rule_o1),
    .o2 (rule_o2)
  );

  // pairing decisions on accepted input, fill count, lookup/rule capture
  always_comb begin
    closed_nxt = closed_r;
    have_nxt   = have_r;
    fja_nxt    = fja_r;
    pend_nxt   = pend_r;
    a_nxt      = a_r;
    b_nxt      = b_r;
    cnt_nxt    = cnt_r;
    c1_nxt     = c1_r;
    o2_nxt     = o2_r;
    go_pair    = 1'b0;
    if (state_r == ST_IDLE && in_acc) begin
      cnt_nxt = '0;
      if (closed_r && op == OP_END) begin
        fja_nxt = 1'b0;
        if (have_r) begin
          have_nxt = 1'b0;
          a_nxt    = pend_r;
          b_nxt    = LetX;
          go_pair  = 1'b1;
        end
      end else if (closed_r && op == OP_TEXT) begin
        if (!dec.ok) begin
          fja_nxt = 1'b0;
        end else if (!have_r) begin
          pend_nxt = dec.idx;
          have_nxt = 1'b1;
          fja_nxt  = 1'b1;
        end else if (fja_r && dec.idx == pend_r) begin
          a_nxt   = pend_r;
          b_nxt   = LetX;
          go_pair = 1'b1;
        end else begin
          a_nxt    = pend_r;
          b_nxt    = dec.idx;
          have_nxt = 1'b0;
          fja_nxt  = 1'b0;
          go_pair  = 1'b1;
        end
      end
    end
    if (state_r == ST_FILL) begin
      cnt_nxt = cnt_r + 5'd1;
      if (cnt_r == LetLast) begin
        closed_nxt = 1'b1;
      end
    end
    if (state_r == ST_LOOK_B) begin
      c1_nxt = cell_rd_data;
    end
    if (state_r == ST_RULE) begin
      o2_nxt = rule_o2;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc && op == OP_CLOSE && !closed_r) begin
          state_nxt = ST_FILL;
        end else if (go_pair) begin
          state_nxt = ST_LOOK_A;
        end
      end
      ST_FILL: begin
        if (cnt_r == LetLast) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_LOOK_A: state_nxt = ST_LOOK_B;
      ST_LOOK_B: state_nxt = ST_RULE;
      ST_RULE:   state_nxt = ST_OUT_1;
      ST_OUT_1: begin
        if (out_tready) begin
          state_nxt = ST_READ_2;
        end
      end
      ST_READ_2: state_nxt = ST_OUT_2;
      ST_OUT_2: begin
        if (out_tready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_tready    = 1'b0;
    out_tvalid   = 1'b0;
    out_tlast    = 1'b0;
    place_req    = '0;
    cell_rd_en   = 1'b0;
    cell_rd_addr = '0;
    sq_rd_en     = 1'b0;
    sq_rd_addr   = '0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready        = 1'b1;
        place_req.en     = in_acc && op == OP_KEY && !closed_r && dec.ok;
        place_req.letter = fold_j(dec.idx);
      end
      ST_FILL: begin
        place_req.en     = (cnt_r != LetJ);
        place_req.letter = cnt_r;
      end
      ST_LOOK_A: begin
        cell_rd_en   = 1'b1;
        cell_rd_addr = fold_j(a_r);
      end
      ST_LOOK_B: begin
        cell_rd_en   = 1'b1;
        cell_rd_addr = fold_j(b_r);
      end
      ST_RULE: begin
        sq_rd_en   = 1'b1;
        sq_rd_addr = rule_o1;
      end
      ST_OUT_1: begin
        out_tvalid = 1'b1;
      end
      ST_READ_2: begin
        sq_rd_en   = 1'b1;
        sq_rd_addr = o2_r;
      end
      ST_OUT_2: begin
        out_tvalid = 1'b1;
        out_tlast  = 1'b1;
      end
      default: begin
        in_tready = 1'b0;
      end
    endcase
  end

  assign out_tdata = {1'b0, 7'(7'd97 + 7'(sq_rd_data))};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      closed_r <= 1'b0;
      have_r   <= 1'b0;
      fja_r    <= 1'b0;
      pend_r   <= '0;
      cnt_r    <= '0;
    end else begin
      state_r  <= state_nxt;
      closed_r <= closed_nxt;
      have_r   <= have_nxt;
      fja_r    <= fja_nxt;
      pend_r   <= pend_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r  <= a_nxt;
    b_r  <= b_nxt;
    c1_r <= c1_nxt;
    o2_r <= o2_nxt;
  end

endmodule

@@ hw/rtl/pfc_key_store.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfc_key_store
// Key square and letter-to-cell map with placement logic and read ports.
// ----------------------------------------------------------------------------
module pfc_key_store
  import pfc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  place_req_t place_req,
  input  logic       cell_rd_en,
  input  letter_t    cell_rd_addr,
  output cell_t      cell_rd_data,
  input  logic       sq_rd_en,
  input  cell_t      sq_rd_addr,
  output letter_t    sq_rd_data
);

  letter_t square_mem [SqCells];
  cell_t   cell_mem   [NumLetter];

  logic [NumLetter-1:0] used_r;
  cell_t                fill_r;
  cell_t                cell_rd_r;
  letter_t              sq_rd_r;
  logic                 do_place;

  assign do_place = place_req.en && (place_req.letter <= LetLast) &&
                    !used_r[place_req.letter] && (fill_r < cell_t'(SqCells));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= '0;
      fill_r <= '0;
    end else if (do_place) begin
      used_r[place_req.letter] <= 1'b1;
      fill_r <= fill_r + 5'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_place) begin
      square_mem[fill_r]          <= place_req.letter;
      cell_mem[place_req.letter]  <= fill_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cell_rd_en) begin
      cell_rd_r <= cell_mem[cell_rd_addr];
    end
    if (sq_rd_en) begin
      sq_rd_r <= square_mem[sq_rd_addr];
    end
  end

  assign cell_rd_data = cell_rd_r;
  assign sq_rd_data   = sq_rd_r;

endmodule

@@ hw/rtl/pfc_pair_rule.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfc_pair_rule
// Row, column and rectangle rule: maps two source cells to two cipher cells.
// ----------------------------------------------------------------------------
module pfc_pair_rule
  import pfc_pkg::*;
(
  input  cell_t c1,
  input  cell_t c2,
  output cell_t o1,
  output cell_t o2
);

  logic [2:0] r1, k1, r2, k2;
  logic [2:0] r1n, k1n, r2n, k2n;

  always_comb begin
    r1  = cell_row(c1);
    k1  = cell_col(c1);
    r2  = cell_row(c2);
    k2  = cell_col(c2);
    r1n = (r1 == 3'd4) ? 3'd0 : r1 + 3'd1;
    k1n = (k1 == 3'd4) ? 3'd0 : k1 + 3'd1;
    r2n = (r2 == 3'd4) ? 3'd0 : r2 + 3'd1;
    k2n = (k2 == 3'd4) ? 3'd0 : k2 + 3'd1;
    if (r1 == r2) begin
      o1 = 5'(r1) * 5'd5 + 5'(k1n);
      o2 = 5'(r2) * 5'd5 + 5'(k2n);
    end else if (k1 == k2) begin
      o1 = 5'(r1n) * 5'd5 + 5'(k1);
      o2 = 5'(r2n) * 5'd5 + 5'(k2);
    end else begin
      o1 = 5'(r1) * 5'd5 + 5'(k2);
      o2 = 5'(r2) * 5'd5 + 5'(k1);
    end
  end

endmodule

@@ hw/rtl/pfc_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfc_checker
// Port-level checks for the Playfair encryption block, bound to the top level.
// ----------------------------------------------------------------------------
module pfc_checker
  import pfc_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       in_tvalid,
  input logic       in_tready,
  input logic [1:0] in_tuser,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic       out_tlast
);

  // hold the input side while a result transaction is pending
  a_busy_on_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready)
    else $error("input ready while result pending");

  a_letter_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[6:0] >= 7'd97 && out_tdata[6:0] <= 7'd122))
    else $error("cipher letter out of range");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("stalled result changed");

  // second letter of the pair still owed
  a_pair_second: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && !out_tlast |=> !in_tready)
    else $error("ready before pair completed");

  a_key_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser == OP_KEY |=> in_tready && !out_tvalid)
    else $error("key byte did not finish in one cycle");

endmodule

bind playfair_cipher_encrypt_top pfc_checker u_pfc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);

@@ tb/sv/playfair_tracker_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// playfair_tracker_pkg
// Tracks the key square and open pair of the Playfair encryption block and
// holds the cipher letters that its accepted input transactions must produce.
// ----------------------------------------------------------------------------
package playfair_tracker_pkg;
  import pfc_pkg::*;

  typedef struct packed {
    logic [6:0] letter;
    logic       last;
  } cipher_out_t;

  class playfair_tracker;
    letter_t     square [SqCells];
    cell_t       home [NumLetter];
    bit          placed [NumLetter];
    int          n_placed;
    bit          closed;
    letter_t     open_letter;
    bit          pair_open;
    bit          open_fresh;
    cipher_out_t due [$];
    int          errors;
    int          letters_seen;

    function new();
      foreach (square[i]) square[i] = '0;
      foreach (home[i]) home[i] = '0;
      foreach (placed[i]) placed[i] = 1'b0;
      n_placed     = 0;
      closed       = 1'b0;
      open_letter  = '0;
      pair_open    = 1'b0;
      open_fresh   = 1'b0;
      errors       = 0;
      letters_seen = 0;
    endfunction

    function void place(letter_t l);
      if (placed[l] || n_placed >= SqCells) return;
      square[n_placed] = l;
      home[l]          = cell_t'(n_placed);
      placed[l]        = 1'b1;
      n_placed++;
    endfunction

    function void encrypt_pair(letter_t a, letter_t b);
      int c1, c2, r1, k1, r2, k2, o1, o2;
      c1 = int'(home[(a == LetJ) ? LetI : a]);
      c2 = int'(home[(b == LetJ) ? LetI : b]);
      r1 = c1 / SqDim;
      k1 = c1 % SqDim;
      r2 = c2 / SqDim;
      k2 = c2 % SqDim;
      if (r1 == r2) begin
        o1 = r1 * SqDim + (k1 + 1) % SqDim;
        o2 = r2 * SqDim + (k2 + 1) % SqDim;
      end else if (k1 == k2) begin
        o1 = ((r1 + 1) % SqDim) * SqDim + k1;
        o2 = ((r2 + 1) % SqDim) * SqDim + k2;
      end else begin
        o1 = r1 * SqDim + k2;
        o2 = r2 * SqDim + k1;
      end
      due.push_back('{7'(int'(square[o1]) + 97), 1'b0});
      due.push_back('{7'(int'(square[o2]) + 97), 1'b1});
    endfunction

    function void accept(op_t op, logic [7:0] ch);
      bit      is_let;
      letter_t l;
      is_let = 1'b0;
      l      = '0;
      if (ch >= 8'h61 && ch <= 8'h7a) begin
        is_let = 1'b1;
        l      = letter_t'(ch - 8'h61);
      end else if (ch >= 8'h41 && ch <= 8'h5a) begin
        is_let = 1'b1;
        l      = letter_t'(ch - 8'h41);
      end
      case (op)
        OP_KEY: begin
          if (!closed && is_let) place((l == LetJ) ? LetI : l);
        end
        OP_CLOSE: begin
          if (!closed) begin
            for (int c = 0; c < NumLetter; c++)
              if (letter_t'(c) != LetJ) place(letter_t'(c));
            closed = 1'b1;
          end
        end
        OP_END: begin
          if (closed) begin
            open_fresh = 1'b0;
            if (pair_open) begin
              pair_open = 1'b0;
              encrypt_pair(open_letter, LetX);
            end
          end
        end
        default: begin
          if (closed) begin
            if (!is_let) begin
              open_fresh = 1'b0;
            end else if (!pair_open) begin
              open_letter = l;
              pair_open   = 1'b1;
              open_fresh  = 1'b1;
            end else if (open_fresh && l == open_letter) begin
              encrypt_pair(open_letter, LetX);
              open_fresh = 1'b1;
            end else begin
              encrypt_pair(open_letter, l);
              pair_open  = 1'b0;
              open_fresh = 1'b0;
            end
          end
        end
      endcase
    endfunction

    function void check(logic [7:0] data, logic last);
      cipher_out_t want;
      if (due.size() == 0) begin
        $display("%0t: unexpected cipher letter, expected none got %0d last %0b",
                 $time, data, last);
        errors++;
        return;
      end
      want = due.pop_front();
      letters_seen++;
      if (data[6:0] !== want.letter) begin
        $display("%0t: cipher letter mismatch, expected %0d got %0d",
                 $time, want.letter, data[6:0]);
        errors++;
      end
      if (data[7] !== 1'b0) begin
        $display("%0t: fill bit mismatch, expected 0 got %0b", $time, data[7]);
        errors++;
      end
      if (last !== want.last) begin
        $display("%0t: pair end mismatch, expected %0b got %0b",
                 $time, want.last, last);
        errors++;
      end
    endfunction

    function int outstanding();
      return due.size();
    endfunction
  endclass

endpackage

@@ tb/sv/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Streams key and plaintext bytes through the Playfair encryption block with
// random idling on both sides and checks every cipher letter and pair end.
// ----------------------------------------------------------------------------
module testbench;
  import pfc_pkg::*;
  import playfair_tracker_pkg::*;

  localparam int CycleLimit = 400000;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_tvalid = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata = '0;
  logic [1:0] in_tuser = '0;
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;
  logic       out_tlast;

  int         tx_idle_pct = 0;
  int         rx_idle_pct = 0;
  int         cycles = 0;
  int         items_sent = 0;
  logic [7:0] last_letter = 8'h61;

  playfair_tracker pf = new();

  playfair_cipher_encrypt_top u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("status: fail");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) pf.check(out_tdata, out_tlast);
    out_tready <= ($urandom_range(99) >= rx_idle_pct);
  end

  task automatic send(op_t op, logic [7:0] ch);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= ch;
    do @(posedge clk); while (!in_tready);
    pf.accept(op, ch);
    items_sent++;
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pf.outstanding() != 0);
  endtask

  task automatic random_text(int n);
    logic [7:0] ch;
    op_t        op;
    int         r;
    int         sent;
    sent = 0;
    while (sent < n) begin
      r  = $urandom_range(99);
      op = OP_TEXT;
      ch = 8'($urandom_range(255));
      if (r < 55) begin
        ch = 8'h61 + 8'($urandom_range(25));
        if ($urandom_range(1)) ch = ch ^ 8'h20;
      end else if (r < 70) begin
        ch = last_letter ^ ($urandom_range(1) ? 8'h20 : 8'h00);
      end else if (r < 76) begin
        ch = $urandom_range(1) ? "j" : "J";
      end else if (r < 84) begin
        do ch = 8'($urandom_range(255));
        while ((ch | 8'h20) >= 8'h61 && (ch | 8'h20) <= 8'h7a);
      end else if (r < 92) begin
        op = OP_END;
      end else if (r < 94) begin
        op = $urandom_range(1) ? OP_KEY : OP_CLOSE;
      end
      if ((ch | 8'h20) >= 8'h61 && (ch | 8'h20) <= 8'h7a && op == OP_TEXT)
        last_letter = ch;
      send(op, ch);
      if (op == OP_TEXT || op == OP_END) sent++;
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    tx_idle_pct = 19;
    rx_idle_pct = 64;
    send(OP_TEXT, "q");
    send(OP_END, 8'h00);
    send(OP_KEY, 8'h00);
    send(OP_KEY, 8'hff);
    send(OP_KEY, "P");
    send(OP_KEY, "l");
    send(OP_KEY, "A");
    send(OP_KEY, "y");
    send(OP_KEY, "@");
    send(OP_KEY, "{");
    send(OP_KEY, "a");
    send(OP_KEY, "J");
    send(OP_KEY, "i");
    send(OP_KEY, "Z");
    send(OP_CLOSE, 8'h00);
    send(OP_KEY, "k");
    send(OP_CLOSE, 8'hff);
    send(OP_TEXT, "x");
    send(OP_TEXT, "x");
    send(OP_TEXT, "z");
    send(OP_TEXT, "j");
    send(OP_TEXT, "I");
    send(OP_TEXT, "b");
    send(OP_TEXT, "%");
    send(OP_TEXT, "B");
    send(OP_TEXT, "q");
    send(OP_END, 8'hff);
    send(OP_END, 8'h00);
    send(OP_TEXT, 8'hff);
    send(OP_TEXT, "a");
    send(OP_TEXT, "Z");
    drain();

    for (int phase = 0; phase < 3; phase++) begin
      tx_idle_pct = (phase == 0) ? 19 : (phase == 1) ? 64 : 0;
      rx_idle_pct = (phase == 0) ? 64 : (phase == 1) ? 19 : 0;
      random_text(285);
      drain();
      random_text(285);
    end

    drain();
    repeat (16) @(posedge clk);
    $display("covered %0d input transactions over key build, close and three idle profiles",
             items_sent);
    $display("compared %0d cipher letters, %0d mismatches", pf.letters_seen, pf.errors);
    if (pf.errors == 0 && pf.outstanding() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
